>>> rtl/newest_frame_slot_ring_assert.svh
// Assertion macros for the frame slot ring.
`ifndef NEWEST_FRAME_SLOT_RING_ASSERT_SVH
`define NEWEST_FRAME_SLOT_RING_ASSERT_SVH

// Check a property on each clock edge outside reset.
`define NFSR_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on each clock edge, reset included.
`define NFSR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/nfsr_pkg.sv
`default_nettype none
package nfsr_pkg;

   localparam int RING_SLOTS = 4;
   localparam int SLOT_W = $clog2(RING_SLOTS);
   localparam int SLOT_IDX_W = 4;
   localparam int CMP_W = SLOT_IDX_W + 1;
   localparam logic [31:0] EXPECTED_VERSION = 32'd1;

   localparam logic [2:0] CMD_PUBLISH_AUTO = 3'd0;
   localparam logic [2:0] CMD_PUBLISH_INTO = 3'd1;
   localparam logic [2:0] CMD_CONSUME      = 3'd2;
   localparam logic [2:0] CMD_RELEASE      = 3'd3;
   localparam logic [2:0] CMD_VALIDATE     = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ARG     = 3'd1;
   localparam logic [2:0] ST_VERSION = 3'd2;
   localparam logic [2:0] ST_SLOT    = 3'd3;
   localparam logic [2:0] ST_BUSY    = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;
   localparam logic [2:0] ST_STALE   = 3'd6;

   localparam logic [1:0] CSR_RING_VERSION = 2'd0;
   localparam logic [1:0] CSR_SLOTS_IN_USE = 2'd1;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] pick;
   } scan_res_type;

endpackage
`default_nettype wire

>>> rtl/nfsr_scan.sv
`default_nettype none
module nfsr_scan import nfsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic [SLOT_W-1:0]     start_slot,
   input  wire logic [CMP_W-1:0]      usable,
   input  wire logic [RING_SLOTS-1:0] busy_vec,
   output scan_res_type               res
);

   logic              run_ff, run_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              hit;
   logic              last;

   assign hit  = ({{(CMP_W-SLOT_W){1'b0}}, cur_ff} < usable) && !busy_vec[cur_ff];
   assign last = (cnt_ff == SLOT_W'(RING_SLOTS - 1));

   always_comb begin
      run_in = run_ff;
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      if (go) begin
         run_in = 1'b1;
         cur_in = start_slot;
         cnt_in = '0;
      end else if (run_ff) begin
         if (hit || last) begin
            run_in = 1'b0;
         end else begin
            cur_in = (cur_ff == SLOT_W'(RING_SLOTS - 1)) ? '0 : cur_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
   end

   assign res.done  = run_ff && (hit || last);
   assign res.found = run_ff && hit;
   assign res.pick  = cur_ff;

endmodule
`default_nettype wire

>>> rtl/newest_frame_slot_ring.sv
// Newest-frame-wins handoff over a ring of slots. A command is taken when start is high
// and busy is low; its result appears on the rsp_ ports for exactly one cycle with
// rsp_valid high and cannot be held off, so capture it then. Auto-slot publish checks
// one slot per cycle in the scan unit, then passes through the execute state to its strobe;
// every other command goes straight from accept to the execute state. Busy is low
// again in the strobe cycle, so the next command may start there. CSR writes are always
// ready and must be issued only while the block is idle.
`default_nettype none
`include "newest_frame_slot_ring_assert.svh"
module newest_frame_slot_ring import nfsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [2:0]            req_command,
   input  wire logic [31:0]           req_frame_version,
   input  wire logic [31:0]           req_surface_id,
   input  wire logic [15:0]           req_frame_width,
   input  wire logic [15:0]           req_frame_height,
   input  wire logic [7:0]            req_pixel_format,
   input  wire logic [SLOT_IDX_W-1:0] req_slot_index,
   output      logic                  rsp_valid,
   output      logic [2:0]            rsp_status,
   output      logic [SLOT_IDX_W-1:0] rsp_frame_slot,
   output      logic [31:0]           rsp_out_sequence,
   output      logic [31:0]           rsp_out_surface,
   output      logic [15:0]           rsp_out_width,
   output      logic [15:0]           rsp_out_height,
   output      logic [7:0]            rsp_out_format,
   output      logic [31:0]           rsp_out_version,
   output      logic                  rsp_newer_pending,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [31:0]           csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;

   logic [31:0] ring_version_ff;
   logic [2:0]  slots_in_use_ff;

   logic [2:0]            cmd_ff;
   logic [31:0]           fver_ff;
   logic [31:0]           surf_ff;
   logic [15:0]           wid_ff;
   logic [15:0]           hgt_ff;
   logic [7:0]            fmt_ff;
   logic [SLOT_IDX_W-1:0] slot_ff;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     pick_ff, pick_in;

   logic [RING_SLOTS-1:0] cbusy_ff, cbusy_in;
   logic [SLOT_W-1:0]     next_start_ff, next_start_in;
   logic [31:0]           pub_cnt_ff, pub_cnt_in;
   logic [31:0]           cons_cnt_ff, cons_cnt_in;
   logic [31:0]           lat_surf_ff, lat_surf_in;
   logic [15:0]           lat_wid_ff, lat_wid_in;
   logic [15:0]           lat_hgt_ff, lat_hgt_in;
   logic [7:0]            lat_fmt_ff, lat_fmt_in;
   logic [31:0]           lat_ver_ff, lat_ver_in;
   logic [SLOT_W-1:0]     lat_slot_ff, lat_slot_in;
   logic [31:0]           lat_seq_ff, lat_seq_in;

   logic                  rsp_valid_ff;
   logic [2:0]            status_in, status_ff;
   logic [SLOT_IDX_W-1:0] oslot_in, oslot_ff;
   logic [31:0]           oseq_in, oseq_ff;
   logic [31:0]           osurf_in, osurf_ff;
   logic [15:0]           owid_in, owid_ff;
   logic [15:0]           ohgt_in, ohgt_ff;
   logic [7:0]            ofmt_in, ofmt_ff;
   logic [31:0]           over_in, over_ff;
   logic                  pend_in, pend_ff;

   logic              accept;
   logic              scan_go;
   logic              ring_ok;
   logic [CMP_W-1:0]  usable;
   logic [2:0]        frame_st;
   logic              range_bad;
   logic              do_publish;
   logic [SLOT_W-1:0] pub_slot;
   logic              consume_ok;
   scan_res_type      scan_res;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign scan_go   = accept && (req_command == CMD_PUBLISH_AUTO);
   assign csr_ready = 1'b1;
   assign ring_ok   = (ring_version_ff == EXPECTED_VERSION);
   assign usable    = (CMP_W'(slots_in_use_ff) > CMP_W'(RING_SLOTS)) ?
                      CMP_W'(RING_SLOTS) : CMP_W'(slots_in_use_ff);

   nfsr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .go         (scan_go),
      .start_slot (next_start_ff),
      .usable     (usable),
      .busy_vec   (cbusy_ff),
      .res        (scan_res)
   );

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      pick_in  = pick_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = scan_go ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            if (scan_res.done) begin
               found_in = scan_res.found;
               pick_in  = scan_res.pick;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign range_bad = ({1'b0, slot_ff} >= usable);
   assign pub_slot  = (cmd_ff == CMD_PUBLISH_AUTO) ? pick_ff : slot_ff[SLOT_W-1:0];

   always_comb begin
      if (!ring_ok || fver_ff != EXPECTED_VERSION) begin
         frame_st = ST_VERSION;
      end else if (surf_ff == '0 || wid_ff == '0 || hgt_ff == '0 || fmt_ff == '0) begin
         frame_st = ST_ARG;
      end else begin
         frame_st = ST_OK;
      end
   end

   always_comb begin
      cbusy_in      = cbusy_ff;
      next_start_in = next_start_ff;
      pub_cnt_in    = pub_cnt_ff;
      cons_cnt_in   = cons_cnt_ff;
      lat_surf_in   = lat_surf_ff;
      lat_wid_in    = lat_wid_ff;
      lat_hgt_in    = lat_hgt_ff;
      lat_fmt_in    = lat_fmt_ff;
      lat_ver_in    = lat_ver_ff;
      lat_slot_in   = lat_slot_ff;
      lat_seq_in    = lat_seq_ff;
      status_in     = ST_OK;
      oslot_in      = '0;
      oseq_in       = '0;
      osurf_in      = '0;
      owid_in       = '0;
      ohgt_in       = '0;
      ofmt_in       = '0;
      over_in       = '0;
      do_publish    = 1'b0;
      case (cmd_ff)
         CMD_PUBLISH_AUTO: begin
            if (!ring_ok) begin
               status_in = ST_VERSION;
            end else if (!found_ff) begin
               status_in = ST_BUSY;
            end else begin
               status_in  = frame_st;
               do_publish = (frame_st == ST_OK);
            end
         end
         CMD_PUBLISH_INTO: begin
            if (frame_st != ST_OK) begin
               status_in = frame_st;
            end else if (range_bad) begin
               status_in = ST_SLOT;
            end else if (cbusy_ff[pub_slot]) begin
               status_in = ST_BUSY;
            end else begin
               do_publish = 1'b1;
            end
         end
         CMD_CONSUME: begin
            if (!ring_ok) begin
               status_in = ST_VERSION;
            end else if (pub_cnt_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (pub_cnt_ff < cons_cnt_ff) begin
               status_in = ST_STALE;
            end else if (pub_cnt_ff == cons_cnt_ff) begin
               status_in = ST_EMPTY;
            end else begin
               cons_cnt_in           = lat_seq_ff;
               cbusy_in[lat_slot_ff] = 1'b1;
               oslot_in              = SLOT_IDX_W'(lat_slot_ff);
               oseq_in               = lat_seq_ff;
               osurf_in              = lat_surf_ff;
               owid_in               = lat_wid_ff;
               ohgt_in               = lat_hgt_ff;
               ofmt_in               = lat_fmt_ff;
               over_in               = lat_ver_ff;
            end
         end
         CMD_RELEASE: begin
            if (!ring_ok) begin
               status_in = ST_VERSION;
            end else if (range_bad) begin
               status_in = ST_SLOT;
            end else begin
               cbusy_in[slot_ff[SLOT_W-1:0]] = 1'b0;
            end
         end
         CMD_VALIDATE: begin
            if (frame_st != ST_OK) begin
               status_in = frame_st;
            end else if (range_bad) begin
               status_in = ST_SLOT;
            end
         end
         default: begin
            status_in = ST_ARG;
         end
      endcase
      if (do_publish) begin
         pub_cnt_in    = pub_cnt_ff + 32'd1;
         lat_seq_in    = pub_cnt_ff + 32'd1;
         lat_slot_in   = pub_slot;
         lat_surf_in   = surf_ff;
         lat_wid_in    = wid_ff;
         lat_hgt_in    = hgt_ff;
         lat_fmt_in    = fmt_ff;
         lat_ver_in    = fver_ff;
         next_start_in = (pub_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : pub_slot + 1'b1;
         oslot_in      = SLOT_IDX_W'(pub_slot);
         oseq_in       = pub_cnt_ff + 32'd1;
      end
      pend_in = ring_ok && (pub_cnt_in != '0) && (pub_cnt_in > cons_cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         ring_version_ff <= 32'd1;
         slots_in_use_ff <= 3'd4;
         cbusy_ff        <= '0;
         next_start_ff   <= '0;
         pub_cnt_ff      <= '0;
         cons_cnt_ff     <= '0;
         lat_surf_ff     <= '0;
         lat_wid_ff      <= '0;
         lat_hgt_ff      <= '0;
         lat_fmt_ff      <= '0;
         lat_ver_ff      <= '0;
         lat_slot_ff     <= '0;
         lat_seq_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RING_VERSION) begin
               ring_version_ff <= csr_data;
            end else if (csr_index == CSR_SLOTS_IN_USE) begin
               slots_in_use_ff <= csr_data[2:0];
            end
         end
         if (state_ff == S_EXEC) begin
            cbusy_ff      <= cbusy_in;
            next_start_ff <= next_start_in;
            pub_cnt_ff    <= pub_cnt_in;
            cons_cnt_ff   <= cons_cnt_in;
            lat_surf_ff   <= lat_surf_in;
            lat_wid_ff    <= lat_wid_in;
            lat_hgt_ff    <= lat_hgt_in;
            lat_fmt_ff    <= lat_fmt_in;
            lat_ver_ff    <= lat_ver_in;
            lat_slot_ff   <= lat_slot_in;
            lat_seq_ff    <= lat_seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pick_ff  <= pick_in;
      if (accept) begin
         cmd_ff  <= req_command;
         fver_ff <= req_frame_version;
         surf_ff <= req_surface_id;
         wid_ff  <= req_frame_width;
         hgt_ff  <= req_frame_height;
         fmt_ff  <= req_pixel_format;
         slot_ff <= req_slot_index;
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
         oslot_ff  <= oslot_in;
         oseq_ff   <= oseq_in;
         osurf_ff  <= osurf_in;
         owid_ff   <= owid_in;
         ohgt_ff   <= ohgt_in;
         ofmt_ff   <= ofmt_in;
         over_ff   <= over_in;
         pend_ff   <= pend_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_frame_slot    = oslot_ff;
   assign rsp_out_sequence  = oseq_ff;
   assign rsp_out_surface   = osurf_ff;
   assign rsp_out_width     = owid_ff;
   assign rsp_out_height    = ohgt_ff;
   assign rsp_out_format    = ofmt_ff;
   assign rsp_out_version   = over_ff;
   assign rsp_newer_pending = pend_ff;

   assign consume_ok = rsp_valid && (cmd_ff == CMD_CONSUME) && (rsp_status == ST_OK);

   `NFSR_ASSERT_CLK(a_strobe_single, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `NFSR_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
   `NFSR_ASSERT_ALWAYS(a_strobe_idle, rsp_valid |-> !busy, "result strobe while still busy")
   `NFSR_ASSERT_CLK(a_consume_pend, consume_ok |-> !rsp_newer_pending, "pending after consume")

endmodule
`default_nettype wire
